/* rtl/core/utf8_to_codepoint_decoder_assert.svh */
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared property forms for the decoder checks
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH

// same-cycle implication, off during reset
`define UCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utf8 decoder check failed");

// next-cycle implication, off during reset
`define UCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utf8 decoder check failed");

`endif

/* rtl/core/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// types and constants shared by the utf8 decoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam int CP_W    = 31;
	localparam int CNT_W   = 3;

	localparam logic [7:0] LEAD2_MASK = 8'h1f;
	localparam logic [7:0] LEAD3_MASK = 8'h0f;
	localparam logic [7:0] LEAD4_MASK = 8'h07;
	localparam logic [7:0] LEAD5_MASK = 8'h03;
	localparam logic [7:0] LEAD6_MASK = 8'h01;
	localparam logic [7:0] FOLLOW_MASK = 8'h3f;

	typedef struct packed {
		logic [CP_W-1:0]  acc;
		logic [CNT_W-1:0] left;
		logic [CNT_W-1:0] taken;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [CNT_W-1:0] byte_count;
		logic             truncated;
	} result_t;

endpackage

/* rtl/core/utf8_to_codepoint_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Byte stream in, code points out, original six-byte UTF-8 scheme. One byte
// (or an end-of-text transfer, tlast set) is taken every clock cycle while
// tready is high; a finished sequence goes through the single combinational
// decode step between the sequence state registers and the result register,
// and is registered there, or in the skid entry if the master side stalls.
// A skid entry behind the result register keeps the slave side open for one
// more result while the master side stalls; tready drops only while both
// entries hold results. Malformed followers shift in zero bits, stray
// continuation bytes and 0xfe/0xff open five follower slots, and tlast
// flushes a partial value with tuser set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_to_codepoint_decoder_assert.svh"

module utf8_to_codepoint_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // text_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [30:0] code_point, [33:31] byte_count, zero pad
	output logic        m_axis_tuser   // truncated
);

	utf8d_pkg::dec_state_t st_q;
	utf8d_pkg::dec_state_t st_nxt;
	utf8d_pkg::result_t    step_res;
	utf8d_pkg::result_t    out_res;
	logic                  step_vld;
	logic                  in_xfer;
	logic                  room;
	logic                  skid_full;

	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = room;

	utf8d_step u_step (
		.cur       (st_q),
		.data_byte (s_axis_tdata),
		.text_end  (s_axis_tlast),
		.nxt       (st_nxt),
		.res_vld   (step_vld),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_xfer) begin
			st_q <= st_nxt;
		end
	end

	utf8d_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_xfer && step_vld),
		.push_res  (step_res),
		.room      (room),
		.out_vld   (m_axis_tvalid),
		.out_rdy   (m_axis_tready),
		.out_res   (out_res),
		.skid_full (skid_full)
	);

	assign m_axis_tdata = {6'd0, out_res.byte_count, out_res.code_point};
	assign m_axis_tuser = out_res.truncated;

	// skid entry only fills behind a waiting result
	`UCD_ASSERT_IMPLY(a_skid_behind_out, clk, arst_n, skid_full, m_axis_tvalid)
	// idle state holds no leftover value
	`UCD_ASSERT_IMPLY(a_idle_clean, clk, arst_n, st_q.left == 3'd0, (st_q.acc == '0) && (st_q.taken == 3'd0))
	// open sequence has consumed one to five bytes
	`UCD_ASSERT_IMPLY(a_open_taken, clk, arst_n, st_q.left != 3'd0, (st_q.taken != 3'd0) && (st_q.taken <= 3'd5))
	// end-of-text always leaves the decoder idle
	`UCD_ASSERT_NEXT(a_flush_idle, clk, arst_n, in_xfer && s_axis_tlast, st_q.left == 3'd0)

endmodule

/* rtl/core/utf8d_step.sv */
// ----------------------------------------------------------------------------
// utf8d_step
// next-state and result logic for one byte or end-of-text transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8d_step (
	input  utf8d_pkg::dec_state_t cur,
	input  logic [7:0]            data_byte,
	input  logic                  text_end,
	output utf8d_pkg::dec_state_t nxt,
	output logic                  res_vld,
	output utf8d_pkg::result_t    res
);

	localparam utf8d_pkg::dec_state_t IDLE_ST = '0;

	logic [5:0]                      follow_bits;
	logic [utf8d_pkg::CP_W-1:0]      acc_shift;
	logic [utf8d_pkg::CNT_W-1:0]     left_dec;
	logic [utf8d_pkg::CNT_W-1:0]     taken_inc;

	assign follow_bits = (data_byte[7:6] == 2'b10) ?
		data_byte[5:0] & utf8d_pkg::FOLLOW_MASK[5:0] : 6'd0;
	assign acc_shift = {cur.acc[utf8d_pkg::CP_W-7:0], follow_bits};
	assign left_dec  = cur.left - 3'd1;
	assign taken_inc = cur.taken + 3'd1;

	always_comb begin
		nxt     = cur;
		res_vld = 1'b0;
		res     = '0;
		if (text_end) begin
			// flush a partial sequence as it stands
			if (cur.left != 3'd0) begin
				res_vld        = 1'b1;
				res.code_point = cur.acc;
				res.byte_count = cur.taken;
				res.truncated  = 1'b1;
				nxt            = IDLE_ST;
			end
		end else if (cur.left == 3'd0) begin
			nxt.taken = 3'd1;
			case (data_byte) inside
				8'b0???????: begin
					res_vld        = 1'b1;
					res.code_point = {23'd0, data_byte};
					res.byte_count = 3'd1;
					nxt            = IDLE_ST;
				end
				8'b110?????: begin
					nxt.acc  = {23'd0, data_byte & utf8d_pkg::LEAD2_MASK};
					nxt.left = 3'd1;
				end
				8'b1110????: begin
					nxt.acc  = {23'd0, data_byte & utf8d_pkg::LEAD3_MASK};
					nxt.left = 3'd2;
				end
				8'b11110???: begin
					nxt.acc  = {23'd0, data_byte & utf8d_pkg::LEAD4_MASK};
					nxt.left = 3'd3;
				end
				8'b111110??: begin
					nxt.acc  = {23'd0, data_byte & utf8d_pkg::LEAD5_MASK};
					nxt.left = 3'd4;
				end
				// stray continuation (0x80..0xbf) or lead 0xfc..0xff
				default: begin
					nxt.acc  = {23'd0, data_byte & utf8d_pkg::LEAD6_MASK};
					nxt.left = 3'd5;
				end
			endcase
		end else begin
			nxt.acc   = acc_shift;
			nxt.left  = left_dec;
			nxt.taken = taken_inc;
			if (left_dec == 3'd0) begin
				res_vld        = 1'b1;
				res.code_point = acc_shift;
				res.byte_count = taken_inc;
				nxt            = IDLE_ST;
			end
		end
	end

endmodule

/* rtl/core/utf8d_out_buf.sv */
// ----------------------------------------------------------------------------
// utf8d_out_buf
// result register with a skid entry so input stays open while output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8d_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  utf8d_pkg::result_t push_res,
	output logic               room,
	output logic               out_vld,
	input  logic               out_rdy,
	output utf8d_pkg::result_t out_res,
	output logic               skid_full
);

	logic               out_vld_q;
	logic               skid_vld_q;
	utf8d_pkg::result_t out_q;
	utf8d_pkg::result_t skid_q;
	logic               pop;

	assign pop       = out_vld_q && out_rdy;
	assign room      = !skid_vld_q;
	assign out_vld   = out_vld_q;
	assign out_res   = out_q;
	assign skid_full = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			if (out_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_res;
			end
		end else if (push) begin
			if (out_vld_q) begin
				skid_q <= push_res;
			end else begin
				out_q <= push_res;
			end
		end
	end

endmodule

/* tb/sv/tb_utf8_to_codepoint_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_codepoint_decoder
// Self-checking bench for the six-byte utf8 decoder. A queue of byte and
// end-of-text transfers is built up front: a directed opening (limits, every
// lead class, stray and 0xfe/0xff leads, malformed followers, flushes), then
// mostly well-formed random sequences mixed with cut-off sequences and noise.
// A negedge driver plays the queue with random gaps and a negedge receiver
// stalls at random. A posedge monitor decodes every accepted byte on its own
// and compares each code point transfer field by field.
// ----------------------------------------------------------------------------

module tb_utf8_to_codepoint_decoder;

	typedef struct {
		logic [7:0]  data;
		logic        eot;
		int unsigned gap;
		bit          drain;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;    // text_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;           // [30:0] code_point, [33:31] byte_count, zero pad
	logic        m_axis_tuser;           // truncated

	utf8_to_codepoint_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	byte_item_t           byte_q[$];
	utf8d_pkg::result_t   pending_cp_q[$];

	// decoder state mirrored by the bench
	logic [utf8d_pkg::CP_W-1:0]  dec_acc = '0;
	logic [utf8d_pkg::CNT_W-1:0] dec_left = '0;
	logic [utf8d_pkg::CNT_W-1:0] dec_taken = '0;

	int unsigned err_cnt = 0;
	int unsigned items_made = 0;
	int unsigned bytes_sent = 0;
	int unsigned ends_sent = 0;
	int unsigned cp_checked = 0;
	int unsigned trunc_checked = 0;
	int unsigned gap_mode = 1;
	bit          drain_next = 1'b0;

	logic        in_fire = 1'b0;
	logic        out_fire = 1'b0;

	function automatic void check_field(string what, logic [31:0] want_v,
			logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
			err_cnt++;
		end
	endfunction

	task automatic decode_transfer(input logic [7:0] b, input logic eot);
		utf8d_pkg::result_t r;
		logic [5:0]         bits;
		if (eot) begin
			// flush only when a sequence is open
			if (dec_left != 0) begin
				r.code_point = dec_acc;
				r.byte_count = dec_taken;
				r.truncated  = 1'b1;
				pending_cp_q = {pending_cp_q, r};
				dec_acc   = '0;
				dec_left  = '0;
				dec_taken = '0;
			end
		end else if (dec_left == 0) begin
			case (b) inside
				8'b0???????: begin
					r.code_point = {23'd0, b};
					r.byte_count = 3'd1;
					r.truncated  = 1'b0;
					pending_cp_q = {pending_cp_q, r};
				end
				8'b110?????: begin
					dec_acc  = {23'd0, b & utf8d_pkg::LEAD2_MASK};
					dec_left = 3'd1;
				end
				8'b1110????: begin
					dec_acc  = {23'd0, b & utf8d_pkg::LEAD3_MASK};
					dec_left = 3'd2;
				end
				8'b11110???: begin
					dec_acc  = {23'd0, b & utf8d_pkg::LEAD4_MASK};
					dec_left = 3'd3;
				end
				8'b111110??: begin
					dec_acc  = {23'd0, b & utf8d_pkg::LEAD5_MASK};
					dec_left = 3'd4;
				end
				// stray continuation (0x80..0xbf) or lead 0xfc..0xff
				default: begin
					dec_acc  = {23'd0, b & utf8d_pkg::LEAD6_MASK};
					dec_left = 3'd5;
				end
			endcase
			if (b[7])
				dec_taken = 3'd1;
		end else begin
			// malformed follower still uses up its slot
			bits = (b[7:6] == 2'b10) ? (b[5:0] & utf8d_pkg::FOLLOW_MASK[5:0]) : 6'd0;
			dec_acc   = {dec_acc[utf8d_pkg::CP_W-7:0], bits};
			dec_taken = dec_taken + 1'b1;
			dec_left  = dec_left - 1'b1;
			if (dec_left == 0) begin
				r.code_point = dec_acc;
				r.byte_count = dec_taken;
				r.truncated  = 1'b0;
				pending_cp_q = {pending_cp_q, r};
				dec_acc   = '0;
				dec_taken = '0;
			end
		end
	endtask

	// monitor: prediction on input transfers, checks on output transfers
	always @(posedge clk or negedge arst_n) begin
		utf8d_pkg::result_t want;
		if (!arst_n) begin
			in_fire  <= 1'b0;
			out_fire <= 1'b0;
			dec_acc   = '0;
			dec_left  = '0;
			dec_taken = '0;
		end else begin
			in_fire  <= s_axis_tvalid && s_axis_tready;
			out_fire <= m_axis_tvalid && m_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				decode_transfer(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_cp_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
						$time, m_axis_tdata, m_axis_tuser);
					err_cnt++;
				end else begin
					want = pending_cp_q.pop_front();
					check_field("code_point", 32'(want.code_point), 32'(m_axis_tdata[30:0]));
					check_field("byte_count", 32'(want.byte_count), 32'(m_axis_tdata[33:31]));
					check_field("truncated", 32'(want.truncated), 32'(m_axis_tuser));
					check_field("tdata pad", 32'd0, 32'(m_axis_tdata[39:34]));
					cp_checked++;
					if (want.truncated)
						trunc_checked++;
				end
			end
		end
	end

	// sender
	int unsigned gap_cnt = 0;
	bit          gap_armed = 1'b0;

	always @(negedge clk) begin
		byte_item_t it;
		logic       v_next;
		logic [7:0] d_next;
		logic       l_next;
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			v_next = 1'b0;
			d_next = 8'($urandom);
			l_next = 1'($urandom);
			if (byte_q.size() != 0) begin
				if (!gap_armed) begin
					gap_cnt   = byte_q[0].gap;
					gap_armed = 1'b1;
				end
				if (byte_q[0].drain && pending_cp_q.size() != 0) begin
					// hold off until the output side has caught up
				end else if (gap_cnt != 0) begin
					gap_cnt--;
				end else begin
					it        = byte_q.pop_front();
					v_next    = 1'b1;
					d_next    = it.data;
					l_next    = it.eot;
					gap_armed = 1'b0;
					if (it.eot)
						ends_sent++;
					else
						bytes_sent++;
				end
			end
			s_axis_tvalid <= v_next;
			s_axis_tdata  <= d_next;
			s_axis_tlast  <= l_next;
		end
	end

	// receiver
	int unsigned rx_wait = 0;
	int unsigned rx_taken = 0;
	bit          rx_armed = 1'b0;
	bit          rx_calm = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire || !rx_armed) begin
				if (out_fire)
					rx_taken++;
				// alternate between stalling and full-rate stretches
				if (rx_taken % 48 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				rx_wait  = rx_calm ? 0 : $urandom_range(0, 11);
				rx_armed = 1'b1;
			end
			if (rx_wait != 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic push_item(input logic [7:0] data, input logic eot);
		byte_item_t it;
		it.data  = data;
		it.eot   = eot;
		it.drain = drain_next;
		case (gap_mode)
			0:       it.gap = 0;
			1:       it.gap = $urandom_range(0, 11);
			default: it.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
		endcase
		drain_next = 1'b0;
		byte_q = {byte_q, it};
		items_made++;
	endtask

	task automatic push_seq(input int unsigned nbytes, input bit cut_short);
		logic [7:0]  lead;
		logic [7:0]  fol;
		int unsigned last;
		lead = 8'($urandom);
		case (nbytes)
			1:       lead[7]   = 1'b0;
			2:       lead[7:5] = 3'b110;
			3:       lead[7:4] = 4'b1110;
			4:       lead[7:3] = 5'b11110;
			5:       lead[7:2] = 6'b111110;
			default: lead[7:1] = 7'b1111110;
		endcase
		push_item(lead, 1'b0);
		last = (cut_short && nbytes > 1) ? $urandom_range(1, nbytes - 1) : nbytes;
		for (int unsigned i = 1; i < last; i++) begin
			fol = {2'b10, 6'($urandom)};
			if ($urandom_range(0, 11) == 0) begin
				fol = 8'($urandom);
				if (fol[7:6] == 2'b10)
					fol[6] = 1'b1;
			end
			push_item(fol, 1'b0);
		end
		if (cut_short)
			push_item(8'($urandom), 1'b1);
	endtask

	initial begin
		int unsigned pick;
		int unsigned next_phase;

		// directed opening
		push_item(8'h00, 1'b0);
		push_item(8'h7f, 1'b0);
		push_item(8'hc3, 1'b0); push_item(8'ha9, 1'b0);
		push_item(8'he2, 1'b0); push_item(8'h82, 1'b0); push_item(8'h00, 1'b0);
		push_item(8'hf4, 1'b0); push_item(8'h8f, 1'b0);
		push_item(8'hbf, 1'b0); push_item(8'hbf, 1'b0);
		push_item(8'hfd, 1'b0);
		repeat (5) push_item(8'hbf, 1'b0);
		drain_next = 1'b1;
		push_item(8'h80, 1'b0); push_item(8'h55, 1'b1);
		push_item(8'hfe, 1'b0); push_item(8'hff, 1'b1);
		push_item(8'hff, 1'b0); push_item(8'h00, 1'b1);
		push_item(8'haa, 1'b1);
		push_item(8'hf8, 1'b0); push_item(8'hc0, 1'b0); push_item(8'h3c, 1'b1);

		// random part in phases of differing sender pace
		next_phase = items_made;
		while (items_made < 1330) begin
			if (items_made >= next_phase) begin
				gap_mode   = $urandom_range(0, 2);
				drain_next = 1'b1;
				next_phase = items_made + 100;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70)
				push_seq($urandom_range(1, 6), 1'b0);
			else if (pick < 80)
				push_seq($urandom_range(2, 6), 1'b1);
			else if (pick < 90)
				push_item(8'($urandom), 1'b0);
			else if (pick < 95)
				push_item({2'b10, 6'($urandom)} | (($urandom_range(0, 1) != 0) ? 8'hfe : 8'h00),
					1'b0);
			else
				push_item(8'($urandom), 1'b1);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (pending_cp_q.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (pending_cp_q.size() != 0) begin
			$display("%0t: missing results: expected %0d more, actual 0",
				$time, pending_cp_q.size());
			err_cnt++;
		end

		$display("sent %0d bytes and %0d end-of-text transfers", bytes_sent, ends_sent);
		$display("checked %0d code points, %0d of them truncated", cp_checked, trunc_checked);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout at %0t", $time);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
